@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the checker module of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property on clk, disabled while rst_n is low.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

@@ hw/rtl/gnms_pkg.sv @@
// Shared constants and types of the gradient non-maximum suppression block.
`default_nettype none

package gnms_pkg;

    // Line buffer depth default and fixed field widths
    localparam int MAX_WIDTH_DEF   = 1024;
    localparam int MAG_BITS        = 16;
    localparam int DIR_BITS        = 9;
    localparam int CFG_BITS        = 11;
    localparam int CFG_INDEX_BITS  = 1;
    localparam int ROW_BITS        = 11;
    localparam int IN_TDATA_BITS   = 32;
    localparam int OUT_TDATA_BITS  = 16;
    localparam int OUT_DEPTH       = 4;
    localparam int OUT_LEVEL_BITS  = $clog2(OUT_DEPTH + 1);

    // Register reset values and limits
    localparam logic [CFG_BITS-1:0] WIDTH_RESET  = CFG_BITS'(640);
    localparam logic [CFG_BITS-1:0] HEIGHT_RESET = CFG_BITS'(480);
    localparam logic [CFG_BITS-1:0] HEIGHT_LIMIT = CFG_BITS'(1024);

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_index_t;

    // Item handed from the position stage to the window stage
    typedef struct packed {
        logic                valid;
        logic                emit;
        logic                last;
        logic                top_ok;
        logic                bot_ok;
        logic                left_ok;
        logic                right_ok;
        logic [MAG_BITS-1:0] mag;
        logic [DIR_BITS-1:0] dir;
    } stage_t;

endpackage

`default_nettype wire

@@ hw/rtl/gnms_line_mem.sv @@
// Line buffer memory: one write and one registered read a cycle, with bypass.
`default_nettype none

module gnms_line_mem #(
    parameter int DEPTH = 1024,
    parameter int DW    = 41
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [DW-1:0]            wr_data,
    output logic      [DW-1:0]            rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_q;
    logic          byp_reg;
    logic [DW-1:0] byp_data_reg;
    logic          byp_next;

    // Write and read the array; a read of the entry being written sees old data
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_q <= mem[rd_addr];
        end
        byp_data_reg <= wr_data;
    end

    // Flag a read that collides with the write of the same cycle
    assign byp_next = rd_en && wr_en && (rd_addr == wr_addr);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_reg <= 1'b0;
        end
        else
        begin
            byp_reg <= byp_next;
        end
    end

    // Forward the fresh write over the stale read
    assign rd_data = byp_reg ? byp_data_reg : rd_q;

endmodule

`default_nettype wire

@@ hw/rtl/gnms_ctrl.sv @@
// Position stage: configuration registers, raster counters and neighbour masks.
`default_nettype none

module gnms_ctrl #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire logic [gnms_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [gnms_pkg::CFG_BITS-1:0]        cfg_data,
    input  wire logic                                 accept,
    input  wire logic                                 cmd,
    input  wire logic [gnms_pkg::MAG_BITS-1:0]        mag,
    input  wire logic [gnms_pkg::DIR_BITS-1:0]        dir,
    output logic      [$clog2(MAX_WIDTH)-1:0]         rd_addr,
    output gnms_pkg::stage_t                          stage,
    output logic      [$clog2(MAX_WIDTH)-1:0]         stage_addr
);

    import gnms_pkg::*;

    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int XW  = $clog2(MAX_WIDTH + 1);
    localparam int CW  = (XW > CFG_BITS) ? XW : CFG_BITS;
    localparam int RSW = ROW_BITS + 2;

    logic [CFG_BITS-1:0] width_reg;
    logic [CFG_BITS-1:0] height_reg;
    logic [AW-1:0]       col_reg;
    logic [ROW_BITS-1:0] row_reg;
    logic [AW-1:0]       col_next;
    logic [ROW_BITS-1:0] row_next;
    stage_t              stage_reg;
    stage_t              stage_next;
    logic [AW-1:0]       addr_reg;

    logic [CW-1:0]         wext;
    logic [XW-1:0]         eff_w;
    logic [CFG_BITS-1:0]   eff_h;
    logic [AW-1:0]         x;
    logic [AW-1:0]         cc;
    logic signed [RSW-1:0] cr;
    logic signed [RSW-1:0] h_s;
    logic signed [RSW-1:0] h_m1;
    logic                  live;
    logic                  x_end;

    // Clamp the width to what the line buffers hold and the height to HEIGHT_LIMIT; zero counts as one
    always_comb
    begin
        wext = CW'(width_reg);
        if (wext == '0)
        begin
            eff_w = XW'(1);
        end
        else if (wext > CW'(MAX_WIDTH))
        begin
            eff_w = XW'(MAX_WIDTH);
        end
        else
        begin
            eff_w = XW'(wext);
        end

        if (height_reg == '0)
        begin
            eff_h = CFG_BITS'(1);
        end
        else if (height_reg > HEIGHT_LIMIT)
        begin
            eff_h = HEIGHT_LIMIT;
        end
        else
        begin
            eff_h = height_reg;
        end
    end

    // Locate the centre pixel that this item completes
    always_comb
    begin
        x     = (XW'(col_reg) >= eff_w) ? '0 : col_reg;
        h_s   = $signed({2'b00, eff_h});
        h_m1  = h_s - RSW'(1);
        cr    = (x != '0) ? $signed({2'b00, row_reg}) - RSW'(1)
                          : $signed({2'b00, row_reg}) - RSW'(2);
        cc    = (x != '0) ? x - AW'(1) : AW'(eff_w - XW'(1));
        live  = !cmd && (row_reg < ROW_BITS'(eff_h));
        x_end = (XW'(x) + XW'(1)) >= eff_w;

        stage_next.valid    = 1'b1;
        stage_next.emit     = !cr[RSW-1] && (cr < h_s);
        stage_next.top_ok   = !cr[RSW-1] && (cr != '0);
        stage_next.bot_ok   = cr < h_m1;
        stage_next.left_ok  = cc != '0;
        stage_next.right_ok = (XW'(cc) + XW'(1)) < eff_w;
        stage_next.last     = (cr == h_m1) && (XW'(cc) == eff_w - XW'(1));
        stage_next.mag      = live ? mag : '0;
        stage_next.dir      = live ? dir : '0;

        // Advance the raster position; restart after the last pixel
        if (stage_next.last)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (x_end)
        begin
            col_next = '0;
            row_next = row_reg + ROW_BITS'(1);
        end
        else
        begin
            col_next = x + AW'(1);
            row_next = row_reg;
        end
    end

    // Hold registers, counters and the stage register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            col_reg    <= '0;
            row_reg    <= '0;
            stage_reg  <= '0;
            addr_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index_t'(cfg_index))
                    REG_IMAGE_WIDTH:
                    begin
                        width_reg <= cfg_data;
                        col_reg   <= '0;
                        row_reg   <= '0;
                    end
                    REG_IMAGE_HEIGHT:
                    begin
                        height_reg <= cfg_data;
                        col_reg    <= '0;
                        row_reg    <= '0;
                    end
                    default:
                    begin
                        col_reg <= col_reg;
                    end
                endcase
            end
            else if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end

            // Load each accepted item into the stage; drop valid otherwise
            if (accept)
            begin
                stage_reg <= stage_next;
                addr_reg  <= x;
            end
            else
            begin
                stage_reg.valid <= 1'b0;
            end
        end
    end

    assign rd_addr    = x;
    assign stage      = stage_reg;
    assign stage_addr = addr_reg;

endmodule

`default_nettype wire

@@ hw/rtl/gnms_window.sv @@
// Window stage: 3x3 magnitude window, angle sector and the maximum test.
`default_nettype none

module gnms_window (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire gnms_pkg::stage_t               stage,
    input  wire logic [gnms_pkg::MAG_BITS-1:0]  rd_up,
    input  wire logic [gnms_pkg::MAG_BITS-1:0]  rd_mid,
    input  wire logic [gnms_pkg::DIR_BITS-1:0]  rd_dir,
    output logic                                push,
    output logic      [gnms_pkg::MAG_BITS-1:0]  push_data,
    output logic                                push_last
);

    import gnms_pkg::*;

    localparam logic [DIR_BITS-1:0] DIR_WRAP  = DIR_BITS'(360);
    localparam logic [DIR_BITS-1:0] DIR_22_5  = DIR_BITS'(45);
    localparam logic [DIR_BITS-1:0] DIR_67_5  = DIR_BITS'(135);
    localparam logic [DIR_BITS-1:0] DIR_112_5 = DIR_BITS'(225);
    localparam logic [DIR_BITS-1:0] DIR_157_5 = DIR_BITS'(315);

    typedef enum logic [1:0] {
        SECTOR_H,
        SECTOR_D45,
        SECTOR_V,
        SECTOR_D135
    } sector_t;

    logic [MAG_BITS-1:0] win_reg [9];
    logic [MAG_BITS-1:0] win_next [9];
    logic [DIR_BITS-1:0] hold_reg;
    logic [DIR_BITS-1:0] ang;
    sector_t             sector;
    logic [MAG_BITS-1:0] fwd_n;
    logic [MAG_BITS-1:0] bwd_n;
    logic [MAG_BITS-1:0] centre;

    // Shift the window left and take the new column
    always_comb
    begin
        win_next[0] = win_reg[1];
        win_next[1] = win_reg[2];
        win_next[2] = rd_up;
        win_next[3] = win_reg[4];
        win_next[4] = win_reg[5];
        win_next[5] = rd_mid;
        win_next[6] = win_reg[7];
        win_next[7] = win_reg[8];
        win_next[8] = stage.mag;
    end

    // Quantise the centre angle into a sector
    always_comb
    begin
        ang = (hold_reg >= DIR_WRAP) ? hold_reg - DIR_WRAP : hold_reg;
        if (ang < DIR_22_5 || ang >= DIR_157_5)
        begin
            sector = SECTOR_H;
        end
        else if (ang < DIR_67_5)
        begin
            sector = SECTOR_D45;
        end
        else if (ang < DIR_112_5)
        begin
            sector = SECTOR_V;
        end
        else
        begin
            sector = SECTOR_D135;
        end
    end

    // Pick the two neighbours along the gradient; outside the image reads zero
    always_comb
    begin
        case (sector)
            SECTOR_H:
            begin
                fwd_n = stage.left_ok  ? win_next[3] : '0;
                bwd_n = stage.right_ok ? win_next[5] : '0;
            end
            SECTOR_D45:
            begin
                fwd_n = (stage.top_ok && stage.right_ok) ? win_next[2] : '0;
                bwd_n = (stage.bot_ok && stage.left_ok)  ? win_next[6] : '0;
            end
            SECTOR_V:
            begin
                fwd_n = stage.top_ok ? win_next[1] : '0;
                bwd_n = stage.bot_ok ? win_next[7] : '0;
            end
            default:
            begin
                fwd_n = (stage.top_ok && stage.left_ok)  ? win_next[0] : '0;
                bwd_n = (stage.bot_ok && stage.right_ok) ? win_next[8] : '0;
            end
        endcase
        centre    = win_next[4];
        push      = stage.valid && stage.emit;
        push_data = (centre >= fwd_n && centre >= bwd_n) ? centre : '0;
        push_last = stage.last;
    end

    // Hold the window and the delayed centre angle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
            begin
                win_reg[i] <= '0;
            end
            hold_reg <= '0;
        end
        else if (stage.valid)
        begin
            for (int i = 0; i < 9; i++)
            begin
                win_reg[i] <= win_next[i];
            end
            hold_reg <= rd_dir;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/gnms_out_fifo.sv @@
// Result queue that parts the window stage from the output channel.
`default_nettype none

module gnms_out_fifo (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 push,
    input  wire logic [gnms_pkg::MAG_BITS-1:0]        push_data,
    input  wire logic                                 push_last,
    input  wire logic                                 pop,
    output logic                                      out_valid,
    output logic      [gnms_pkg::MAG_BITS-1:0]        out_data,
    output logic                                      out_last,
    output logic      [gnms_pkg::OUT_LEVEL_BITS-1:0]  level
);

    import gnms_pkg::*;

    localparam int PW = $clog2(OUT_DEPTH);

    logic [MAG_BITS:0]       entry_reg [OUT_DEPTH];
    logic [PW-1:0]           wr_ptr_reg;
    logic [PW-1:0]           rd_ptr_reg;
    logic [OUT_LEVEL_BITS-1:0] count_reg;
    logic [OUT_LEVEL_BITS-1:0] count_next;

    // Store each pushed item
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= {push_last, push_data};
        end
    end

    always_comb
    begin
        count_next = count_reg + OUT_LEVEL_BITS'(push) - OUT_LEVEL_BITS'(pop);
    end

    // Advance the pointers and the fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            count_reg <= count_next;
        end
    end

    assign out_valid = count_reg != '0;
    assign out_data  = entry_reg[rd_ptr_reg][MAG_BITS-1:0];
    assign out_last  = entry_reg[rd_ptr_reg][MAG_BITS];
    assign level     = count_reg;

endmodule

`default_nettype wire

@@ hw/rtl/gradient_non_maximum_suppression_core.sv @@
// Top level of the Canny non-maximum suppression block.
`default_nettype none

// Takes one gradient pixel per clock in raster order and gives one thinned
// magnitude per clock once the pipe is full: an item is accepted every cycle
// as long as the result queue drains. The first result of a frame appears one
// row plus one pixel after its input; the pixel itself passes through a pipe
// of line buffer read, then window and compare. One memory of MAX_WIDTH
// entries holds the two magnitude rows and the direction row side by side;
// it is read and written once per cycle, so that port sets the rate.
// Line buffer contents left from reset or from an earlier frame only ever fall
// on neighbours outside the image, which read as zero, so no clearing pass is
// run. Send flush items (tuser high) after the frame to drain the last row;
// a configuration write restarts the frame.
module gradient_non_maximum_suppression_core #(
    parameter int MAX_WIDTH = gnms_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // Configuration write port
    input  wire logic                                 cfg_we,
    input  wire logic [gnms_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [gnms_pkg::CFG_BITS-1:0]        cfg_data,
    // Input stream
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    // [15:0] magnitude, [24:16] direction, [31:25] zero
    input  wire logic [gnms_pkg::IN_TDATA_BITS-1:0]   s_axis_tdata,
    // [0] cmd
    input  wire logic                                 s_axis_tuser,
    // Output stream
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    // [15:0] thinned
    output logic      [gnms_pkg::OUT_TDATA_BITS-1:0]  m_axis_tdata,
    output logic                                      m_axis_tlast
);

    import gnms_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int DW = 2 * MAG_BITS + DIR_BITS;

    logic                      accept;
    logic [AW-1:0]             rd_addr;
    stage_t                    stage;
    logic [AW-1:0]             stage_addr;
    logic [DW-1:0]             rd_data;
    logic [DW-1:0]             wr_data;
    logic [MAG_BITS-1:0]       rd_up;
    logic [MAG_BITS-1:0]       rd_mid;
    logic [DIR_BITS-1:0]       rd_dir;
    logic                      push;
    logic [MAG_BITS-1:0]       push_data;
    logic                      push_last;
    logic [OUT_LEVEL_BITS-1:0] level;
    logic [MAG_BITS-1:0]       out_data;

    // Take an item only when the queue has room for it and the one in flight
    assign s_axis_tready = (level + OUT_LEVEL_BITS'(stage.valid))
                           < OUT_LEVEL_BITS'(OUT_DEPTH);
    assign accept        = s_axis_tvalid && s_axis_tready;

    gnms_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .accept     (accept),
        .cmd        (s_axis_tuser),
        .mag        (s_axis_tdata[MAG_BITS-1:0]),
        .dir        (s_axis_tdata[MAG_BITS+DIR_BITS-1:MAG_BITS]),
        .rd_addr    (rd_addr),
        .stage      (stage),
        .stage_addr (stage_addr)
    );

    // Older row moves up, new pixel and angle take their place
    assign wr_data = {rd_mid, stage.mag, stage.dir};

    gnms_line_mem #(
        .DEPTH (MAX_WIDTH),
        .DW    (DW)
    ) u_line_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .wr_en   (stage.valid),
        .wr_addr (stage_addr),
        .wr_data (wr_data),
        .rd_data (rd_data)
    );

    assign rd_up  = rd_data[DW-1:MAG_BITS+DIR_BITS];
    assign rd_mid = rd_data[MAG_BITS+DIR_BITS-1:DIR_BITS];
    assign rd_dir = rd_data[DIR_BITS-1:0];

    gnms_window u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .stage     (stage),
        .rd_up     (rd_up),
        .rd_mid    (rd_mid),
        .rd_dir    (rd_dir),
        .push      (push),
        .push_data (push_data),
        .push_last (push_last)
    );

    gnms_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .push_last (push_last),
        .pop       (m_axis_tvalid && m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_data  (out_data),
        .out_last  (m_axis_tlast),
        .level     (level)
    );

    assign m_axis_tdata = OUT_TDATA_BITS'(out_data);

endmodule

`default_nettype wire

@@ hw/rtl/gnms_checker.sv @@
// Port checker for the non-maximum suppression core, bound to the top level.
`default_nettype none

`include "assert_macros.svh"

module gnms_checker (
    input wire logic                                 clk,
    input wire logic                                 rst_n,
    input wire logic                                 s_axis_tvalid,
    input wire logic                                 s_axis_tready,
    input wire logic                                 m_axis_tvalid,
    input wire logic                                 m_axis_tready,
    input wire logic [gnms_pkg::OUT_TDATA_BITS-1:0]  m_axis_tdata,
    input wire logic                                 m_axis_tlast
);

    logic                                in_take;
    logic                                out_stall;
    logic [gnms_pkg::OUT_TDATA_BITS:0]   out_item;

    assign in_take   = s_axis_tvalid && s_axis_tready;
    assign out_stall = m_axis_tvalid && !m_axis_tready;
    assign out_item  = {m_axis_tlast, m_axis_tdata};

    // A stalled result item keeps its valid and its payload
    `ASSERT_CLK(a_out_hold, out_stall |=> m_axis_tvalid && $stable(out_item), "stalled item changed")

    // A result item appears on an empty output only after an input item is taken
    `ASSERT_CLK(a_out_cause, !in_take ##1 !m_axis_tvalid |=> !m_axis_tvalid, "result without an input item")

    // With the result queue empty the input side must take items
    `ASSERT_NEVER(a_empty_ready, !m_axis_tvalid && !s_axis_tready, "input stalled with empty queue")

endmodule

bind gradient_non_maximum_suppression_core gnms_checker u_gnms_checker (.*);

`default_nettype wire
